### rtl/core/bspline_basis_evaluator_unit_defines.svh
// Assertion macros for the B-spline basis evaluator.
`ifndef BSPLINE_BASIS_EVALUATOR_UNIT_DEFINES_SVH
`define BSPLINE_BASIS_EVALUATOR_UNIT_DEFINES_SVH

`ifndef SYNTH
`define BSBE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("bsbe assertion failed");
`define BSBE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsbe assertion failed");
`else
`define BSBE_ASSERT(lbl, cond)
`define BSBE_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

### rtl/core/bsbe_pkg.sv
`timescale 1ns / 1ps
package bsbe_pkg;
  localparam int DEGREE     = 3;
  localparam int MAX_CP     = 64;
  localparam int KNOT_DEPTH = MAX_CP + DEGREE + 1;
  localparam int MIN_CP     = ((DEGREE + 1) > 4) ? (DEGREE + 1) : 4;
  localparam int KNOT_AW    = $clog2(KNOT_DEPTH);
  localparam int CNT_W      = 7;
  localparam int VAL_W      = 17;
  localparam int IDX_W      = 6;
  localparam int WIN        = DEGREE + 1;
  localparam int KK_N       = 2 * DEGREE;
  localparam int P_W        = $clog2(WIN);
  localparam int D_W        = $clog2(DEGREE + 1);
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic KIND_KNOT = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef logic [VAL_W-1:0] q16_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIRST, ST_LAST, ST_CLAMP, ST_SRCH, ST_SPAN,
    ST_KNOT, ST_TERM, ST_WAIT, ST_COMMIT, ST_OUT
  } main_state_e;

  typedef enum logic [2:0] {
    DV_IDLE, DV_MUL, DV_CHK, DV_RUN, DV_DONE
  } div_state_e;

  typedef struct packed {
    logic start;
    logic zero;
    q16_t num;
    q16_t den;
    q16_t v;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    q16_t quo;
  } div_rsp_t;
endpackage

### rtl/core/bsbe_div.sv
`timescale 1ns / 1ps
module bsbe_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsbe_pkg::div_req_t req_i,
  output bsbe_pkg::div_rsp_t rsp_o
);
  import bsbe_pkg::*;

  div_state_e state_q, state_d;
  q16_t num_q, den_q, v_q;
  logic [2*VAL_W:0] prod_q;
  logic [VAL_W-1:0] rem_q;
  logic [VAL_W-1:0] quo_q;
  logic [4:0] cnt_q;
  logic ovf;
  logic [VAL_W:0] trial;
  logic ge;
  logic [VAL_W-1:0] low;

  assign low   = prod_q[VAL_W-1:0];
  assign ovf   = prod_q[2*VAL_W:VAL_W] >= {1'b0, den_q};
  assign trial = {rem_q, low[cnt_q]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          state_d = req_i.zero ? DV_DONE : DV_MUL;
        end
      end
      DV_MUL: state_d = DV_CHK;
      DV_CHK: state_d = ovf ? DV_DONE : DV_RUN;
      DV_RUN: begin
        if (cnt_q == '0) begin
          state_d = DV_DONE;
        end
      end
      DV_DONE: state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.busy = (state_q != DV_IDLE);
    rsp_o.done = (state_q == DV_DONE);
    rsp_o.quo  = (quo_q > ONE_Q16) ? ONE_Q16 : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          num_q <= req_i.num;
          den_q <= req_i.den;
          v_q   <= req_i.v;
          quo_q <= '0;
        end
      end
      DV_MUL: begin
        prod_q <= ({{(VAL_W+1){1'b0}}, num_q} * {{(VAL_W+1){1'b0}}, v_q}) +
                  {{(VAL_W+1){1'b0}}, den_q >> 1};
      end
      DV_CHK: begin
        if (ovf) begin
          quo_q <= ONE_Q16;
        end else begin
          rem_q <= prod_q[2*VAL_W-1:VAL_W];
          quo_q <= '0;
          cnt_q <= 5'(VAL_W - 1);
        end
      end
      DV_RUN: begin
        rem_q <= ge ? VAL_W'(trial - {1'b0, den_q}) : trial[VAL_W-1:0];
        quo_q <= {quo_q[VAL_W-2:0], ge};
        cnt_q <= cnt_q - 5'd1;
      end
      default: begin
      end
    endcase
  end
endmodule

### rtl/core/bspline_basis_evaluator_unit.sv
// Knot word: written to the knot table when its index is in range, no result.
// Evaluate word: first and last knot reads and a clamp of t, a span search, a knot
// fetch, 12 divider terms, 9 weight commits, n result words; t at an end skips to the results.
// One item at a time; the shared divider and the single knot port set the pace.
// Asynchronous active-low reset; knot table is undefined until written.
`timescale 1ns / 1ps
`include "bspline_basis_evaluator_unit_defines.svh"
module bspline_basis_evaluator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // knot_index[6:0], knot_value[23:7], param_t[40:24]
  input  logic [bsbe_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // kind
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // basis_index[5:0], basis_value[22:6]
  output logic [bsbe_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bsbe_pkg::CNT_W-1:0]         cfg_data_i
);
  import bsbe_pkg::*;

  main_state_e state_q, state_d;
  logic [CNT_W-1:0] ncfg_q, n_q, m_w, n_sat;
  q16_t t_q, first_q, prev_q, rdata_q;
  logic [CNT_W-1:0] cnt_q, base_q, oj_q;
  q16_t kk_q [KK_N];
  q16_t w_q [WIN];
  logic [D_W-1:0] d_q;
  logic [P_W-1:0] p_q;
  logic side_q;
  logic [VAL_W:0] acc_q;
  q16_t knot_mem [KNOT_DEPTH];
  logic [KNOT_AW-1:0] raddr;
  logic mvalid_q, mlast_q;
  logic [IDX_W-1:0] midx_q;
  q16_t mval_q;

  logic in_acc, hit, srch_end, en_a, en_b, out_load;
  q16_t t_lo, t_c, ka, kad, kb1, kbd, va, vb, wsel;
  logic signed [VAL_W:0] num_s, den_s;
  logic [CNT_W-1:0] k_sat, rel;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign m_w      = n_q + CNT_W'(DEGREE + 1);
  assign n_sat    = (ncfg_q < CNT_W'(MIN_CP)) ? CNT_W'(MIN_CP) :
                    (ncfg_q > CNT_W'(MAX_CP)) ? CNT_W'(MAX_CP) : ncfg_q;
  assign t_lo     = (t_q < first_q) ? first_q : t_q;
  assign t_c      = (t_lo > rdata_q) ? rdata_q : t_lo;
  assign hit      = (cnt_q >= CNT_W'(2)) && (t_q >= prev_q) && (t_q < rdata_q);
  assign srch_end = (cnt_q == m_w);
  assign k_sat    = (base_q < CNT_W'(DEGREE)) ? CNT_W'(DEGREE) :
                    (base_q > n_q - CNT_W'(1)) ? n_q - CNT_W'(1) : base_q;
  assign en_a     = (int'(p_q) != DEGREE - int'(d_q));
  assign en_b     = (int'(p_q) != DEGREE);
  assign out_load = !mvalid_q || m_axis_tready;
  assign rel      = oj_q - base_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    ka = '0; kad = '0; kb1 = '0; kbd = '0; va = '0; vb = '0; wsel = '0;
    for (int x = 0; x < KK_N; x++) begin
      if (x + 1 == int'(p_q)) ka = kk_q[x];
      if (x + 1 == int'(p_q) + int'(d_q)) kad = kk_q[x];
      if (x == int'(p_q)) kb1 = kk_q[x];
      if (x == int'(p_q) + int'(d_q)) kbd = kk_q[x];
    end
    for (int x = 0; x < WIN; x++) begin
      if (x == int'(p_q)) va = w_q[x];
      if (x == int'(p_q) + 1) vb = w_q[x];
      if ((oj_q >= base_q) && (int'(rel) == x)) wsel = w_q[x];
    end
    if (side_q) begin
      num_s = $signed({1'b0, kbd}) - $signed({1'b0, t_q});
      den_s = $signed({1'b0, kbd}) - $signed({1'b0, kb1});
    end else begin
      num_s = $signed({1'b0, t_q}) - $signed({1'b0, ka});
      den_s = $signed({1'b0, kad}) - $signed({1'b0, ka});
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == KIND_EVAL)) state_d = ST_FIRST;
      end
      ST_FIRST: state_d = ST_LAST;
      ST_LAST:  state_d = ST_CLAMP;
      ST_CLAMP: begin
        if ((t_c == first_q) || (t_c == rdata_q)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (hit || srch_end) state_d = ST_SPAN;
      end
      ST_SPAN: state_d = ST_KNOT;
      ST_KNOT: begin
        if (cnt_q == CNT_W'(KK_N)) state_d = ST_TERM;
      end
      ST_TERM: begin
        if (side_q ? en_b : en_a) begin
          state_d = ST_WAIT;
        end else if (side_q) begin
          state_d = ST_COMMIT;
        end
      end
      ST_WAIT: begin
        if (div_rsp.done) state_d = side_q ? ST_COMMIT : ST_TERM;
      end
      ST_COMMIT: begin
        if ((int'(p_q) == DEGREE) && (int'(d_q) == DEGREE)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_TERM;
        end
      end
      ST_OUT: begin
        if (out_load && (oj_q == n_q - CNT_W'(1))) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    div_req.start = (state_q == ST_TERM) && (side_q ? en_b : en_a);
    div_req.num   = num_s[VAL_W-1:0];
    div_req.den   = den_s[VAL_W-1:0];
    div_req.v     = side_q ? vb : va;
    div_req.zero  = num_s[VAL_W] || (num_s == '0) || den_s[VAL_W] || (den_s == '0) ||
                    (div_req.v == '0);
    case (state_q)
      ST_FIRST: raddr = '0;
      ST_LAST:  raddr = KNOT_AW'(m_w - CNT_W'(1));
      ST_SRCH:  raddr = (cnt_q < CNT_W'(KNOT_DEPTH)) ? KNOT_AW'(cnt_q) : '0;
      ST_KNOT:  raddr = KNOT_AW'(base_q + CNT_W'(1) + cnt_q);
      default:  raddr = '0;
    endcase
  end

  bsbe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc && (s_axis_tuser == KIND_KNOT) &&
        (s_axis_tdata[6:0] < CNT_W'(KNOT_DEPTH))) begin
      knot_mem[KNOT_AW'(s_axis_tdata[6:0])] <= s_axis_tdata[23:7];
    end
    rdata_q <= knot_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ncfg_q   <= CNT_W'(4);
      mvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) ncfg_q <= cfg_data_i;
      if (state_q == ST_OUT && out_load) begin
        mvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        mvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          t_q <= s_axis_tdata[40:24];
          n_q <= n_sat;
        end
      end
      ST_LAST: first_q <= rdata_q;
      ST_CLAMP: begin
        t_q    <= t_c;
        cnt_q  <= '0;
        oj_q   <= '0;
        d_q    <= D_W'(1);
        p_q    <= P_W'(DEGREE - 1);
        side_q <= 1'b0;
        acc_q  <= '0;
        if (t_c == first_q) begin
          base_q <= '0;
          for (int x = 0; x < WIN; x++) w_q[x] <= (x == 0) ? ONE_Q16 : '0;
        end else begin
          base_q <= n_q - CNT_W'(DEGREE + 1);
          for (int x = 0; x < WIN; x++) w_q[x] <= (x == DEGREE) ? ONE_Q16 : '0;
        end
      end
      ST_SRCH: begin
        prev_q <= rdata_q;
        cnt_q  <= cnt_q + CNT_W'(1);
        if (hit) begin
          base_q <= cnt_q - CNT_W'(2);
        end else if (srch_end) begin
          base_q <= '0;
        end
      end
      ST_SPAN: begin
        base_q <= k_sat - CNT_W'(DEGREE);
        cnt_q  <= '0;
      end
      ST_KNOT: begin
        cnt_q <= cnt_q + CNT_W'(1);
        for (int x = 0; x < KK_N; x++) begin
          if (int'(cnt_q) == x + 1) kk_q[x] <= rdata_q;
        end
      end
      ST_TERM: begin
        if (!side_q && !en_a) side_q <= 1'b1;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          acc_q  <= acc_q + {1'b0, div_rsp.quo};
          side_q <= 1'b1;
        end
      end
      ST_COMMIT: begin
        w_q[p_q] <= (acc_q > {1'b0, ONE_Q16}) ? ONE_Q16 : acc_q[VAL_W-1:0];
        acc_q    <= '0;
        side_q   <= 1'b0;
        if (int'(p_q) == DEGREE) begin
          d_q <= d_q + D_W'(1);
          p_q <= P_W'(DEGREE - int'(d_q) - 1);
        end else begin
          p_q <= p_q + P_W'(1);
        end
      end
      ST_OUT: begin
        if (out_load) begin
          midx_q  <= oj_q[IDX_W-1:0];
          mval_q  <= wsel;
          mlast_q <= (oj_q == n_q - CNT_W'(1));
          oj_q    <= oj_q + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {1'b0, mval_q, midx_q};
  assign m_axis_tlast  = mlast_q;

  `BSBE_ASSERT_IMPL(a_idle_div, s_axis_tready, !div_rsp.busy)
  `BSBE_ASSERT_IMPL(a_mid_word_in_out, mvalid_q && !mlast_q, state_q == ST_OUT)
  `BSBE_ASSERT_IMPL(a_wait_busy, state_q == ST_WAIT, div_rsp.busy)
endmodule

### tb/bspline_basis_evaluator_unit_tb.sv
`timescale 1ns / 1ps
module bspline_basis_evaluator_unit_tb;
  import bsbe_pkg::*;

  typedef struct {
    logic       kind;
    logic [6:0] knot_idx;
    q16_t       knot_val;
    q16_t       param_t;
  } spline_word_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    q16_t             val;
    logic             last;
  } basis_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i = '0;

  spline_word_t word_q[$];
  basis_word_t  basis_q[$];
  q16_t         knot_mem[KNOT_DEPTH];
  int           cp_count = 4;
  int           err_cnt = 0;
  int           eval_cnt = 0;
  int           knot_cnt = 0;
  int           result_cnt = 0;
  int           cfg_cnt = 0;
  int           burst_left = 4;
  int           gap_left = 0;
  int           hold_left = 0;
  int           holds_done = 0;

  bspline_basis_evaluator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint ratio_term(longint num, longint den, longint v);
    longint q;
    if (den <= 0 || num <= 0 || v == 0) return 0;
    q = (num * v + (den >>> 1)) / den;
    return (q > ONE_Q16) ? longint'(ONE_Q16) : q;
  endfunction

  task automatic predict_basis(spline_word_t w);
    longint kv[KNOT_DEPTH];
    longint work[MAX_CP];
    longint t, a, b;
    int n, m, k, d, i;
    basis_word_t r;
    if (w.kind == KIND_KNOT) begin
      if (w.knot_idx < KNOT_DEPTH) knot_mem[w.knot_idx] = w.knot_val;
      return;
    end
    n = cp_count;
    if (n < MIN_CP) n = MIN_CP;
    if (n > MAX_CP) n = MAX_CP;
    m = n + DEGREE + 1;
    for (i = 0; i < KNOT_DEPTH; i++) kv[i] = longint'(knot_mem[i]);
    for (i = 0; i < MAX_CP; i++) work[i] = 0;
    t = longint'(w.param_t);
    if (t < kv[0]) t = kv[0];
    if (t > kv[m-1]) t = kv[m-1];
    if (t == kv[0]) begin
      work[0] = ONE_Q16;
    end else if (t == kv[m-1]) begin
      work[n-1] = ONE_Q16;
    end else begin
      k = 0;
      for (i = 0; i + 1 < m; i++) begin
        if (t >= kv[i] && t < kv[i+1]) begin
          k = i;
          break;
        end
      end
      if (k < DEGREE) k = DEGREE;
      if (k > n - 1) k = n - 1;
      work[k] = ONE_Q16;
      for (d = 1; d <= DEGREE; d++) begin
        work[k-d] = ratio_term(kv[k+1] - t, kv[k+1] - kv[k-d+1], work[k-d+1]);
        for (i = k - d + 1; i < k; i++) begin
          a = ratio_term(t - kv[i], kv[i+d] - kv[i], work[i]);
          b = ratio_term(kv[i+d+1] - t, kv[i+d+1] - kv[i+1], work[i+1]);
          work[i] = (a + b > ONE_Q16) ? longint'(ONE_Q16) : a + b;
        end
        work[k] = ratio_term(t - kv[k], kv[k+d] - kv[k], work[k]);
      end
    end
    for (i = 0; i < n; i++) begin
      r.idx  = i[IDX_W-1:0];
      r.val  = work[i][VAL_W-1:0];
      r.last = (i == n - 1);
      basis_q.push_back(r);
    end
  endtask

  // sender: bursts with random gaps, hold word until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    spline_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        w = word_q.pop_front();
        predict_basis(w);
        if (w.kind == KIND_EVAL) eval_cnt++;
        else knot_cnt++;
      end
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (word_q.size() > 0) begin
        w = word_q[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.kind;
        s_axis_tdata  <= {7'd0, w.param_t, w.knot_val, w.knot_idx};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: check each result word, stall on its own pattern
  always @(posedge clk_i or negedge rst_ni) begin
    basis_word_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt++;
        if (basis_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result word %h last %b", $realtime, m_axis_tdata,
                   m_axis_tlast);
        end else begin
          e = basis_q.pop_front();
          if (m_axis_tdata[5:0] !== e.idx || m_axis_tdata[22:6] !== e.val ||
              m_axis_tlast !== e.last) begin
            err_cnt++;
            $display("%0t: expected idx %0d val %0d last %b, got idx %0d val %0d last %b",
                     $realtime, e.idx, e.val, e.last, m_axis_tdata[5:0],
                     m_axis_tdata[22:6], m_axis_tlast);
          end
        end
        if ((result_cnt == 40 && holds_done == 0) ||
            (result_cnt == 900 && holds_done == 1)) begin
          hold_left = 700;
          holds_done++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case ((result_cnt / 97) % 3)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  task automatic push_word(logic kind, int idx, int kval, int t);
    spline_word_t w;
    w.kind     = kind;
    w.knot_idx = idx[6:0];
    w.knot_val = kval[VAL_W-1:0];
    w.param_t  = t[VAL_W-1:0];
    word_q.push_back(w);
  endtask

  task automatic wait_idle();
    while (word_q.size() > 0 || s_axis_tvalid || basis_q.size() > 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
  endtask

  task automatic write_count(int v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[CNT_W-1:0];
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    cp_count = v;
    cfg_cnt++;
  endtask

  // load a knot vector for n points: clamped, repeated or out of order
  task automatic load_knots(int n, ref int vals[KNOT_DEPTH]);
    int m, lo, hi, style, i, j, tmp;
    m = n + DEGREE + 1;
    style = $urandom_range(0, 9);
    lo = (style < 6) ? 0 : $urandom_range(0, 20000);
    hi = (style < 6) ? 65536 : $urandom_range(40000, 131071);
    for (i = 0; i < m; i++) begin
      if (i <= DEGREE) vals[i] = lo;
      else if (i >= m - DEGREE - 1) vals[i] = hi;
      else vals[i] = $urandom_range(lo, hi);
    end
    for (i = DEGREE + 1; i < m - DEGREE - 1; i++)
      for (j = i + 1; j < m - DEGREE - 1; j++)
        if (vals[j] < vals[i]) begin
          tmp = vals[i]; vals[i] = vals[j]; vals[j] = tmp;
        end
    if (style == 4 && n > 5) vals[DEGREE + 2] = vals[DEGREE + 1];
    if (style == 9) vals[$urandom_range(1, m - 2)] = $urandom_range(0, 131071);
    for (i = 0; i < m; i++) push_word(KIND_KNOT, i, vals[i], $urandom());
    if ($urandom_range(0, 2) == 0)
      push_word(KIND_KNOT, $urandom_range(KNOT_DEPTH, 127), $urandom(), $urandom());
  endtask

  initial begin
    int vals[KNOT_DEPTH];
    int phase, n, cnt, i, sel, mt;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cubic Bezier on [0, 1] at reset count
    for (i = 0; i < 8; i++) push_word(KIND_KNOT, i, (i < 4) ? 0 : 65536, 0);
    push_word(KIND_KNOT, 127, 17'h1FFFF, 17'h1FFFF);
    push_word(KIND_EVAL, 0, 0, 0);
    push_word(KIND_EVAL, 0, 0, 65536);
    push_word(KIND_EVAL, 0, 0, 32768);
    push_word(KIND_EVAL, 0, 0, 17'h1FFFF);
    push_word(KIND_EVAL, 127, 17'h1FFFF, 1);
    push_word(KIND_EVAL, 0, 0, 65535);
    wait_idle();

    phase = 0;
    while (knot_cnt + eval_cnt < 350) begin
      case (phase)
        0: cnt = 64;
        1: cnt = 0;
        2: cnt = 127;
        3: cnt = 4;
        default: begin
          sel = $urandom_range(0, 9);
          cnt = (sel < 7) ? $urandom_range(4, 10) :
                (sel < 9) ? $urandom_range(0, 64) : $urandom_range(65, 127);
        end
      endcase
      write_count(cnt);
      n = (cnt < MIN_CP) ? MIN_CP : (cnt > MAX_CP) ? MAX_CP : cnt;
      mt = n + DEGREE;
      load_knots(n, vals);
      for (i = 0; i < ((n > 16) ? 4 : $urandom_range(8, 16)); i++) begin
        sel = $urandom_range(0, 9);
        case (sel)
          0: push_word(KIND_EVAL, $urandom(), $urandom(), vals[0]);
          1: push_word(KIND_EVAL, $urandom(), $urandom(), vals[mt]);
          2: push_word(KIND_EVAL, $urandom(), $urandom(), vals[$urandom_range(0, mt)]);
          3: push_word(KIND_EVAL, $urandom(), $urandom(), $urandom_range(0, 131071));
          default: push_word(KIND_EVAL, $urandom(), $urandom(),
                             (vals[mt] > vals[0]) ?
                             $urandom_range(vals[0], vals[mt]) : vals[0]);
        endcase
      end
      wait_idle();
      phase++;
    end

    $display("covered %0d knot writes, %0d evaluations, %0d result words",
             knot_cnt, eval_cnt, result_cnt);
    $display("over %0d count settings, including 0, 4, 64 and 127", cfg_cnt);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #18_000_000;
    $display("timeout after %0t", $realtime);
    $display("status: fail");
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/bsbe_pkg.sv
rtl/core/bsbe_div.sv
rtl/core/bspline_basis_evaluator_unit.sv
tb/bspline_basis_evaluator_unit_tb.sv
